// File: hw/rtl/tsfs_pkg.sv
package tsfs_pkg;

   localparam int ID_BITS = 6;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_YIELD  = 2'd1;
   localparam logic [1:0] KIND_EXIT   = 2'd2;
   localparam logic [1:0] KIND_KILL   = 2'd3;

   localparam logic [1:0] MODE_ID   = 2'd0;
   localparam logic [1:0] MODE_SELF = 2'd1;
   localparam logic [1:0] MODE_ANY  = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NONE    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;
   localparam logic [1:0] STATUS_NOFREE  = 2'd3;

   typedef enum logic [2:0] {
      ST_EMPTY  = 3'd0,
      ST_RUN    = 3'd1,
      ST_READY  = 3'd2,
      ST_EXITED = 3'd3,
      ST_KILLED = 3'd4
   } slot_st_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         target_mode;
      logic [ID_BITS-1:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ID_BITS-1:0] result_id;
      logic [ID_BITS-1:0] running_id;
      logic               must_exit;
   } rsp_type;

endpackage

// File: hw/rtl/thread_slot_fifo_scheduler_top.sv
// Kill is a single slot check; create is a linear scan for a free slot;
// yield and exit walk the ready queue links, one entry per cycle, and pass through
// an extra dispatch state when a thread is dispatched.
// One command at a time; the result register lets the next start.
// Reset: a clearing pass initializes the slot table, req_stall high.
module thread_slot_fifo_scheduler_top import tsfs_pkg::*; #(
   parameter int MAX_THREADS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    core_idle;
   logic    core_done;
   logic    out_free;
   rsp_type core_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   tsfs_core #(
      .MAX_THREADS(MAX_THREADS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .cmd      (req_data),
      .idle     (core_idle),
      .out_free (out_free),
      .done     (core_done),
      .rsp      (core_rsp)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !core_idle;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/tsfs_core.sv
module tsfs_core import tsfs_pkg::*; #(
   parameter int MAX_THREADS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type cmd,
   output logic    idle,
   input  logic    out_free,
   output logic    done,
   output rsp_type rsp
);

   localparam int IDW = $clog2(MAX_THREADS);
   localparam int CW  = $clog2(MAX_THREADS + 1);
   localparam int W   = (IDW > ID_BITS) ? IDW : ID_BITS;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_SWEEP  = 8'b0000_1000,
      S_DECIDE = 8'b0001_0000,
      S_DISP   = 8'b0010_0000,
      S_KILL   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } fsm_type;

   fsm_type          state_ff, state_in;
   logic [IDW-1:0]   idx_ff, idx_in;
   logic [IDW-1:0]   run_ff, run_in;
   slot_st_type      run_st_ff, run_st_in;
   logic [IDW-1:0]   head_ff, head_in;
   logic [IDW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   req_type          cmd_ff, cmd_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [IDW-1:0]   cur_ff, cur_in;
   logic [CW-1:0]    kcnt_ff, kcnt_in;
   logic [IDW-1:0]   khead_ff, khead_in;
   logic [IDW-1:0]   klast_ff, klast_in;
   logic             tfnd_ff, tfnd_in;
   logic             tfirst_ff, tfirst_in;
   logic             tnfnd_ff, tnfnd_in;
   logic             tkill_ff, tkill_in;
   logic [IDW-1:0]   tid_ff, tid_in;
   logic [IDW-1:0]   tpred_ff, tpred_in;
   logic [IDW-1:0]   tnext_ff, tnext_in;
   logic [1:0]       status_ff, status_in;
   logic [IDW-1:0]   rid_ff, rid_in;
   logic             mexit_ff, mexit_in;

   slot_st_type      st_mem [MAX_THREADS];
   logic [IDW-1:0]   nx_mem [MAX_THREADS];
   slot_st_type      st_rd_ff;
   logic [IDW-1:0]   nx_rd_ff;

   logic [IDW-1:0]   st_raddr, st_waddr, nx_raddr, nx_waddr, nx_wdata;
   logic             st_we, nx_we;
   slot_st_type      st_wdata;

   logic [W-1:0]     tid_w, req_tid_w, run_w, cur_w, rid_w;
   logic             tid_ok, is_self, head_mode, keep, match, disp, last;
   logic [IDW-1:0]   tail1, head1;
   slot_st_type      old_new;

   always_comb begin
      tid_w     = W'(cmd_ff.target_id);
      req_tid_w = W'(cmd.target_id);
      run_w     = W'(run_ff);
      cur_w     = W'(cur_ff);
      rid_w     = W'(rid_ff);
      tid_ok    = {1'b0, tid_w} < (W+1)'(MAX_THREADS);
      is_self   = (cmd_ff.target_mode == MODE_SELF) ||
                  ((cmd_ff.target_mode == MODE_ID) && (tid_w == run_w));
      head_mode = (cmd_ff.kind == KIND_EXIT) || (cmd_ff.target_mode == MODE_ANY);
      keep      = (st_rd_ff != ST_EXITED);
      match     = head_mode ? (kcnt_ff == '0) : (cur_w == tid_w);
      last      = !tnfnd_ff;
      tail1     = last ? tpred_ff : klast_ff;
      head1     = tfirst_ff ? tnext_ff : khead_ff;
      if (cmd_ff.kind == KIND_EXIT) begin
         disp = tfnd_ff;
      end else begin
         disp = tfnd_ff && !is_self &&
                ((cmd_ff.target_mode == MODE_ANY) || (cmd_ff.target_mode == MODE_ID));
      end
      if (cmd_ff.kind == KIND_EXIT) begin
         old_new = ST_EXITED;
      end else if (run_st_ff == ST_RUN) begin
         old_new = ST_READY;
      end else begin
         old_new = run_st_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      run_in    = run_ff;
      run_st_in = run_st_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      left_in   = left_ff;
      cur_in    = cur_ff;
      kcnt_in   = kcnt_ff;
      khead_in  = khead_ff;
      klast_in  = klast_ff;
      tfnd_in   = tfnd_ff;
      tfirst_in = tfirst_ff;
      tnfnd_in  = tnfnd_ff;
      tkill_in  = tkill_ff;
      tid_in    = tid_ff;
      tpred_in  = tpred_ff;
      tnext_in  = tnext_ff;
      status_in = status_ff;
      rid_in    = rid_ff;
      mexit_in  = mexit_ff;
      st_raddr  = head_ff;
      nx_raddr  = head_ff;
      st_we     = 1'b0;
      st_waddr  = idx_ff;
      st_wdata  = ST_EMPTY;
      nx_we     = 1'b0;
      nx_waddr  = tail_ff;
      nx_wdata  = idx_ff;
      done      = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_wdata = (idx_ff == '0) ? ST_RUN : ST_EMPTY;
            if (idx_ff == IDW'(MAX_THREADS - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            // The first read of each command goes out with the accept.
            if (cmd.kind == KIND_CREATE) begin
               st_raddr = '0;
            end else if (cmd.kind == KIND_KILL) begin
               st_raddr = req_tid_w[IDW-1:0];
            end
            if (start) begin
               cmd_in    = cmd;
               idx_in    = '0;
               left_in   = cnt_ff;
               cur_in    = head_ff;
               kcnt_in   = '0;
               tfnd_in   = 1'b0;
               tfirst_in = 1'b0;
               tnfnd_in  = 1'b0;
               tkill_in  = 1'b0;
               status_in = STATUS_OK;
               rid_in    = '0;
               mexit_in  = 1'b0;
               case (cmd.kind)
                  KIND_CREATE: state_in = S_SCAN;
                  KIND_KILL:   state_in = S_KILL;
                  default:     state_in = (cnt_ff == '0) ? S_DECIDE : S_SWEEP;
               endcase
            end
         end
         S_SCAN: begin
            st_raddr = idx_ff + 1'b1;
            if (st_rd_ff == ST_EMPTY) begin
               st_we    = 1'b1;
               st_wdata = ST_READY;
               if (cnt_ff == '0) begin
                  head_in = idx_ff;
               end else begin
                  nx_we = 1'b1;
               end
               tail_in  = idx_ff;
               cnt_in   = cnt_ff + 1'b1;
               rid_in   = idx_ff;
               state_in = S_DONE;
            end else if (idx_ff == IDW'(MAX_THREADS - 1)) begin
               status_in = STATUS_NOFREE;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SWEEP: begin
            // One queue entry per cycle; exited entries are unlinked and freed.
            st_raddr = nx_rd_ff;
            nx_raddr = nx_rd_ff;
            cur_in   = nx_rd_ff;
            left_in  = left_ff - 1'b1;
            if (!keep) begin
               st_we    = 1'b1;
               st_waddr = cur_ff;
               st_wdata = ST_EMPTY;
            end else begin
               if (kcnt_ff == '0) begin
                  khead_in = cur_ff;
               end else begin
                  nx_we    = 1'b1;
                  nx_waddr = klast_ff;
                  nx_wdata = cur_ff;
               end
               klast_in = cur_ff;
               kcnt_in  = kcnt_ff + 1'b1;
               if (tfnd_ff && !tnfnd_ff) begin
                  tnext_in = cur_ff;
                  tnfnd_in = 1'b1;
               end
               if (match && !tfnd_ff) begin
                  tfnd_in   = 1'b1;
                  tid_in    = cur_ff;
                  tpred_in  = klast_ff;
                  tfirst_in = (kcnt_ff == '0);
                  tkill_in  = (st_rd_ff == ST_KILLED);
               end
            end
            if (left_ff == CW'(1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (disp) begin
               st_we     = 1'b1;
               st_waddr  = run_ff;
               st_wdata  = old_new;
               nx_we     = !tfirst_ff && !last;
               nx_waddr  = tpred_ff;
               nx_wdata  = tnext_ff;
               idx_in    = run_ff;
               run_in    = tid_ff;
               run_st_in = tkill_ff ? ST_KILLED : ST_RUN;
               cnt_in    = kcnt_ff;
               tail_in   = run_ff;
               head_in   = (kcnt_ff == CW'(1)) ? run_ff : head1;
               rid_in    = tid_ff;
               mexit_in  = tkill_ff;
               state_in  = S_DISP;
            end else begin
               cnt_in   = kcnt_ff;
               head_in  = (kcnt_ff == '0) ? '0 : khead_ff;
               tail_in  = (kcnt_ff == '0) ? '0 : klast_ff;
               state_in = S_DONE;
               if (cmd_ff.kind == KIND_YIELD && is_self) begin
                  rid_in = run_ff;
               end else if (head_mode) begin
                  status_in = STATUS_NONE;
               end else begin
                  status_in = STATUS_INVALID;
               end
            end
         end
         S_DISP: begin
            // The old thread is linked behind the last remaining entry and becomes the new tail.
            nx_we    = (kcnt_ff != CW'(1));
            nx_waddr = tail1;
            nx_wdata = idx_ff;
            st_we    = !tkill_ff;
            st_waddr = tid_ff;
            st_wdata = ST_RUN;
            state_in = S_DONE;
         end
         S_KILL: begin
            if (cmd_ff.target_mode == MODE_ID && tid_w != run_w && tid_ok &&
                st_rd_ff == ST_READY) begin
               st_we    = 1'b1;
               st_waddr = tid_w[IDW-1:0];
               st_wdata = ST_KILLED;
               rid_in   = tid_w[IDW-1:0];
            end else begin
               status_in = STATUS_INVALID;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            done = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         idx_ff    <= '0;
         run_ff    <= '0;
         run_st_ff <= ST_RUN;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         run_ff    <= run_in;
         run_st_ff <= run_st_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      left_ff   <= left_in;
      cur_ff    <= cur_in;
      kcnt_ff   <= kcnt_in;
      khead_ff  <= khead_in;
      klast_ff  <= klast_in;
      tfnd_ff   <= tfnd_in;
      tfirst_ff <= tfirst_in;
      tnfnd_ff  <= tnfnd_in;
      tkill_ff  <= tkill_in;
      tid_ff    <= tid_in;
      tpred_ff  <= tpred_in;
      tnext_ff  <= tnext_in;
      status_ff <= status_in;
      rid_ff    <= rid_in;
      mexit_ff  <= mexit_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rd_ff <= st_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         nx_mem[nx_waddr] <= nx_wdata;
      end
      nx_rd_ff <= nx_mem[nx_raddr];
   end

   assign idle            = (state_ff == S_IDLE);
   assign rsp.status      = status_ff;
   assign rsp.result_id   = rid_w[ID_BITS-1:0];
   assign rsp.running_id  = run_w[ID_BITS-1:0];
   assign rsp.must_exit   = mexit_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_THREADS))
      else $error("queue count exceeds slot count");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle after a result");

   a_sweep_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> left_ff != '0)
      else $error("queue walk ran past the queue length");

   a_run_state: assert property (@(posedge clock) disable iff (reset)
      run_st_ff == ST_RUN || run_st_ff == ST_EXITED || run_st_ff == ST_KILLED)
      else $error("running thread holds a ready or empty state");

   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DISP |-> cnt_ff != '0)
      else $error("dispatch left an empty queue");

endmodule
